// ===== design/vtd_pkg.sv =====
// ----------------------------------------------------------------------------
// vtd_pkg
// Shared types and constants of the vertex triplet dedup table.
// ----------------------------------------------------------------------------
package vtd_pkg;

    // output vertex numbers
    localparam int unsigned SLOT_W     = 13;
    localparam int unsigned VNUM_W     = 14;
    localparam int unsigned SLOT_LIMIT = 8192;

    // hash is 64*position + 5*normal + 32*uv
    localparam int unsigned HASH_POS_SHIFT = 6;
    localparam int unsigned HASH_UV_SHIFT  = 5;
    localparam int unsigned HASH_NRM_SHIFT = 2;
    // bits the weighted sum grows beyond one index
    localparam int unsigned HASH_GROWTH    = 7;

    // one result
    typedef struct packed {
        logic [SLOT_W-1:0] vertex_slot;
        logic              is_new;
        logic              table_full;
    } t_res;

    // table engine states
    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_REPLY,
        BK_IDLE,
        BK_PROBE,
        BK_LINK
    } t_back_state;

endpackage

// ===== design/vtd_ifs.sv =====
// ----------------------------------------------------------------------------
// vtd request and result channels
// Valid/ready channels carrying one face corner and one lookup result.
// ----------------------------------------------------------------------------
interface vtd_req_if #(
    parameter int IDX_W = 20
);
    logic             valid;
    logic             ready;
    logic             mode;
    logic [IDX_W-1:0] position_index;
    logic             uv_present;
    logic [IDX_W-1:0] uv_index;
    logic [IDX_W-1:0] normal_index;

    modport source (
        output valid, mode, position_index, uv_present, uv_index, normal_index,
        input  ready
    );
    modport sink (
        input  valid, mode, position_index, uv_present, uv_index, normal_index,
        output ready
    );
endinterface

interface vtd_res_if;
    logic                        valid;
    logic                        ready;
    logic [vtd_pkg::SLOT_W-1:0]  vertex_slot;
    logic                        is_new;
    logic                        table_full;

    modport source (
        output valid, vertex_slot, is_new, table_full,
        input  ready
    );
    modport sink (
        input  valid, vertex_slot, is_new, table_full,
        output ready
    );
endinterface

// ===== design/vertex_triplet_dedup_table.sv =====
// ----------------------------------------------------------------------------
// vertex_triplet_dedup_table
// Chained hash table that numbers unique position/uv/normal corner triplets.
// ----------------------------------------------------------------------------
// Each request is one face corner (mode 0) or a clear for a new mesh (mode 1),
// and each gives exactly one result. The front hashes the corner straight into
// a register when BUCKETS is a power of two (otherwise by a reciprocal
// multiply, a multiply-back and one correction) and hands it through a
// two-entry queue to the table engine.
// The engine is one chain probe per cycle through the single-port key and
// link memories: a corner reads its bucket head, probes each chain entry in
// turn and, when it is appended from the overflow pool, writes the new link
// word in a further state. After reset and after every clear the engine
// sweeps the BUCKETS bucket heads, one a cycle, before it takes the next
// request; requests queue up meanwhile. Results wait in an output register;
// a full register holds the engine, and a full queue then holds the front.
module vertex_triplet_dedup_table #(
    parameter int BUCKETS      = 4096,
    parameter int POOL_ENTRIES = 4096,
    parameter int INDEX_BITS   = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vtd_req_if.sink        i_req,
    vtd_res_if.source      o_res
);
    localparam int KEY_W = 3 * INDEX_BITS + 1;
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int REQ_W = 1 + KEY_W + BKT_W;

    logic             w_push_valid;
    logic             w_push_ready;
    logic [REQ_W-1:0] w_push_data;
    logic             w_pop_valid;
    logic             w_pop_ready;
    logic [REQ_W-1:0] w_pop_data;
    vtd_pkg::t_res    w_res;

    // hash front
    vtd_front #(
        .BUCKETS    (BUCKETS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .o_req_ready  (i_req.ready),
        .i_mode       (i_req.mode),
        .i_pos        (i_req.position_index[INDEX_BITS-1:0]),
        .i_uvp        (i_req.uv_present),
        .i_uv         (i_req.uv_index[INDEX_BITS-1:0]),
        .i_nrm        (i_req.normal_index[INDEX_BITS-1:0]),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // request queue
    vtd_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // table engine
    vtd_back #(
        .BUCKETS      (BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res)
    );

    assign o_res.vertex_slot = w_res.vertex_slot;
    assign o_res.is_new      = w_res.is_new;
    assign o_res.table_full  = w_res.table_full;

    // a full result never carries a vertex number or a new flag
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.table_full) |-> (o_res.vertex_slot == '0 && !o_res.is_new))
        else $error("table full result carries a vertex");

    // no result right out of reset: the head sweep runs first
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

    // a request the front holds is not dropped while the queue is full
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && !w_push_ready) |=> w_push_valid)
        else $error("front request lost while queue full");

endmodule

// ===== design/vtd_front.sv =====
// ----------------------------------------------------------------------------
// vtd_front
// Accepts face corners, normalizes the key and computes the hash bucket.
// ----------------------------------------------------------------------------
module vtd_front #(
    parameter int BUCKETS    = 4096,
    parameter int INDEX_BITS = 20
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_req_valid,
    output logic                                   o_req_ready,
    input  logic                                   i_mode,
    input  logic [INDEX_BITS-1:0]                  i_pos,
    input  logic                                   i_uvp,
    input  logic [INDEX_BITS-1:0]                  i_uv,
    input  logic [INDEX_BITS-1:0]                  i_nrm,
    output logic                                   o_push_valid,
    input  logic                                   i_push_ready,
    output logic [1+3*INDEX_BITS+1+$clog2(BUCKETS)-1:0] o_push_data
);
    localparam int KEY_W = 3 * INDEX_BITS + 1;
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int SUM_W = INDEX_BITS + vtd_pkg::HASH_GROWTH;

    logic              w_accept;
    logic              w_push;
    logic [INDEX_BITS-1:0] w_uv_eff;
    logic [KEY_W-1:0]  w_key;
    logic [SUM_W-1:0]  w_sum;
    logic [BKT_W-1:0]  w_bkt;
    logic              r_valid;
    logic              r_mode;
    logic [KEY_W-1:0]  r_key;

    assign w_accept = i_req_valid && o_req_ready;
    assign w_push   = r_valid && i_push_ready;

    // a missing uv reads as zero in both the key and the hash
    assign w_uv_eff = i_uvp ? i_uv : '0;
    assign w_key    = {i_pos, i_uvp, w_uv_eff, i_nrm};
    assign w_sum    = SUM_W'({i_pos, vtd_pkg::HASH_POS_SHIFT'(0)})
                    + SUM_W'({i_nrm, vtd_pkg::HASH_NRM_SHIFT'(0)})
                    + SUM_W'(i_nrm)
                    + SUM_W'({w_uv_eff, vtd_pkg::HASH_UV_SHIFT'(0)});

    // captured key
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_key  <= w_key;
        end
    end

    generate
        if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
            localparam int EXT_W = (SUM_W > BKT_W) ? SUM_W : BKT_W;
            logic [EXT_W-1:0] w_sum_ext;
            logic [BKT_W-1:0] r_bkt;

            assign w_sum_ext   = EXT_W'(w_sum);
            assign o_req_ready = !r_valid || i_push_ready;
            assign w_bkt       = r_bkt;

            // power-of-two bucket count: the remainder is the low bits
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid <= 1'b0;
                end else if (w_accept) begin
                    r_valid <= 1'b1;
                end else if (w_push) begin
                    r_valid <= 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_accept) begin
                    r_bkt <= w_sum_ext[BKT_W-1:0];
                end
            end
        end else begin : g_divide
            localparam int RS     = SUM_W + BKT_W;
            localparam int REC_W  = SUM_W + 1;
            localparam int PROD_W = SUM_W + REC_W;
            localparam int EXT_W  = ((SUM_W > BKT_W) ? SUM_W : BKT_W) + 1;
            localparam longint unsigned RECIP = (64'd1 << RS) / 64'(BUCKETS);
            logic              r_busy;
            logic              r_phase;
            logic [SUM_W-1:0]  r_sum;
            logic [EXT_W-1:0]  r_quo;
            logic [EXT_W-1:0]  r_rem_est;
            logic [REC_W-1:0]  w_recip;
            logic [PROD_W-1:0] w_prod;
            logic [EXT_W-1:0]  w_quo;
            logic [EXT_W-1:0]  w_back;
            logic [EXT_W-1:0]  w_rem_est;
            logic [EXT_W-1:0]  w_bkt_ext;

            assign o_req_ready = !r_valid && !r_busy;

            // quotient estimate from the floor reciprocal, low by at most one
            assign w_recip   = REC_W'(RECIP);
            assign w_prod    = PROD_W'(r_sum) * PROD_W'(w_recip);
            assign w_quo     = EXT_W'(w_prod >> RS);
            // remainder estimate, below twice the bucket count
            assign w_back    = r_quo * EXT_W'(BUCKETS);
            assign w_rem_est = EXT_W'(r_sum) - w_back;
            // one compare and subtract finishes the remainder
            assign w_bkt_ext = (r_rem_est >= EXT_W'(BUCKETS))
                             ? r_rem_est - EXT_W'(BUCKETS) : r_rem_est;
            assign w_bkt     = w_bkt_ext[BKT_W-1:0];

            // two steps after accept: quotient, then remainder estimate
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid <= 1'b0;
                    r_busy  <= 1'b0;
                    r_phase <= 1'b0;
                end else if (w_accept) begin
                    r_busy  <= 1'b1;
                    r_phase <= 1'b0;
                end else if (r_busy) begin
                    r_phase <= 1'b1;
                    if (r_phase) begin
                        r_busy  <= 1'b0;
                        r_valid <= 1'b1;
                    end
                end else if (w_push) begin
                    r_valid <= 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_accept) begin
                    r_sum <= w_sum;
                end
                if (r_busy && !r_phase) begin
                    r_quo <= w_quo;
                end
                if (r_busy && r_phase) begin
                    r_rem_est <= w_rem_est;
                end
            end
        end
    endgenerate

    assign o_push_valid = r_valid;
    assign o_push_data  = {r_mode, r_key, w_bkt};

endmodule

// ===== design/vtd_fifo.sv =====
// ----------------------------------------------------------------------------
// vtd_fifo
// Short request queue between the hash front and the table engine.
// ----------------------------------------------------------------------------
module vtd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== design/vtd_back.sv =====
// ----------------------------------------------------------------------------
// vtd_back
// Table engine: walks bucket chains, inserts new triplets, clears the table.
// ----------------------------------------------------------------------------
module vtd_back #(
    parameter int BUCKETS      = 4096,
    parameter int POOL_ENTRIES = 4096,
    parameter int INDEX_BITS   = 20
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_pop_valid,
    output logic                                   o_pop_ready,
    input  logic [1+3*INDEX_BITS+1+$clog2(BUCKETS)-1:0] i_pop_data,
    output logic                                   o_res_valid,
    input  logic                                   i_res_ready,
    output vtd_pkg::t_res                          o_res
);
    localparam int KEY_W   = 3 * INDEX_BITS + 1;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int REQ_W   = 1 + KEY_W + BKT_W;
    localparam int TOTAL   = BUCKETS + POOL_ENTRIES;
    localparam int ENTRY_W = $clog2(TOTAL);
    localparam int POOL_W  = $clog2(POOL_ENTRIES + 1);
    localparam int SLOT_W  = vtd_pkg::SLOT_W;
    localparam int VNUM_W  = vtd_pkg::VNUM_W;
    // link word: valid, has_next, next entry, vertex number
    localparam int LINK_W  = 2 + ENTRY_W + SLOT_W;
    localparam int L_VALID = LINK_W - 1;
    localparam int L_HAS   = LINK_W - 2;

    // memories
    logic [KEY_W-1:0]  r_key_mem  [TOTAL];
    logic [LINK_W-1:0] r_link_mem [TOTAL];
    logic [KEY_W-1:0]  r_key_rd;
    logic [LINK_W-1:0] r_link_rd;

    // engine state
    vtd_pkg::t_back_state r_state, n_state;
    logic [BKT_W-1:0]  r_clr_idx, n_clr_idx;
    logic              r_reply, n_reply;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [ENTRY_W-1:0] r_e, n_e;
    logic              r_head, n_head;
    logic [VNUM_W-1:0] r_vnum, n_vnum;
    logic [POOL_W-1:0] r_pool, n_pool;
    logic [ENTRY_W-1:0] r_fresh, n_fresh;
    logic              r_out_valid;
    vtd_pkg::t_res     r_out;

    // control
    logic              w_req_mode;
    logic [KEY_W-1:0]  w_req_key;
    logic [BKT_W-1:0]  w_req_bkt;
    logic              w_out_free;
    logic              w_load;
    vtd_pkg::t_res     w_load_data;
    logic              w_rd_en;
    logic [ENTRY_W-1:0] w_rd_addr;
    logic              w_key_we;
    logic [ENTRY_W-1:0] w_key_waddr;
    logic              w_link_we;
    logic [ENTRY_W-1:0] w_link_waddr;
    logic [LINK_W-1:0] w_link_wdata;
    logic              w_hit;
    logic              w_vnum_full;
    logic              w_pool_full;
    logic [ENTRY_W-1:0] w_fresh;
    logic              w_l_valid;
    logic              w_l_has;
    logic [ENTRY_W-1:0] w_l_next;
    logic [SLOT_W-1:0] w_l_vertex;

    assign w_req_mode = i_pop_data[REQ_W-1];
    assign w_req_key  = i_pop_data[REQ_W-2:BKT_W];
    assign w_req_bkt  = i_pop_data[BKT_W-1:0];

    assign w_l_valid  = r_link_rd[L_VALID];
    assign w_l_has    = r_link_rd[L_HAS];
    assign w_l_next   = r_link_rd[LINK_W-3:SLOT_W];
    assign w_l_vertex = r_link_rd[SLOT_W-1:0];

    assign w_out_free  = !r_out_valid || i_res_ready;
    assign w_hit       = r_key_rd == r_key;
    assign w_vnum_full = r_vnum >= VNUM_W'(vtd_pkg::SLOT_LIMIT);
    assign w_pool_full = r_pool >= POOL_W'(POOL_ENTRIES);
    assign w_fresh     = ENTRY_W'(BUCKETS) + ENTRY_W'(r_pool);

    // key and link memories, registered read
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_key_waddr] <= r_key;
        end
        if (w_rd_en) begin
            r_key_rd <= r_key_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_link_mem[w_link_waddr] <= w_link_wdata;
        end
        if (w_rd_en) begin
            r_link_rd <= r_link_mem[w_rd_addr];
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vtd_pkg::BK_CLEAR;
            r_clr_idx <= '0;
            r_reply   <= 1'b0;
            r_vnum    <= '0;
            r_pool    <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_reply   <= n_reply;
            r_vnum    <= n_vnum;
            r_pool    <= n_pool;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_e     <= n_e;
        r_head  <= n_head;
        r_fresh <= n_fresh;
    end

    // next state and memory control
    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_reply      = r_reply;
        n_key        = r_key;
        n_e          = r_e;
        n_head       = r_head;
        n_vnum       = r_vnum;
        n_pool       = r_pool;
        n_fresh      = r_fresh;
        o_pop_ready  = 1'b0;
        w_load       = 1'b0;
        w_load_data  = '0;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_e;
        w_key_we     = 1'b0;
        w_key_waddr  = r_e;
        w_link_we    = 1'b0;
        w_link_waddr = r_e;
        w_link_wdata = '0;

        case (r_state)
            // sweep bucket heads invalid; pool entries are tracked by the fill count
            vtd_pkg::BK_CLEAR: begin
                w_link_we    = 1'b1;
                w_link_waddr = ENTRY_W'(r_clr_idx);
                if (r_clr_idx == BKT_W'(BUCKETS - 1)) begin
                    n_clr_idx = '0;
                    n_state   = r_reply ? vtd_pkg::BK_REPLY : vtd_pkg::BK_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end

            // clear done: all-zero result
            vtd_pkg::BK_REPLY: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_reply = 1'b0;
                    n_state = vtd_pkg::BK_IDLE;
                end
            end

            // take the next request and read its bucket head
            vtd_pkg::BK_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    if (w_req_mode) begin
                        n_state = vtd_pkg::BK_CLEAR;
                        n_reply = 1'b1;
                        n_vnum  = '0;
                        n_pool  = '0;
                    end else begin
                        n_key     = w_req_key;
                        n_e       = ENTRY_W'(w_req_bkt);
                        n_head    = 1'b1;
                        w_rd_en   = 1'b1;
                        w_rd_addr = ENTRY_W'(w_req_bkt);
                        n_state   = vtd_pkg::BK_PROBE;
                    end
                end
            end

            // examine one chain entry per cycle, holding on the last while the result register is full
            vtd_pkg::BK_PROBE: begin
                if (r_head && !w_l_valid) begin
                    // empty bucket head
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = vtd_pkg::BK_IDLE;
                        if (w_vnum_full) begin
                            w_load_data.table_full = 1'b1;
                        end else begin
                            w_key_we     = 1'b1;
                            w_link_we    = 1'b1;
                            w_link_wdata = {1'b1, 1'b0, ENTRY_W'(0), r_vnum[SLOT_W-1:0]};
                            w_load_data.vertex_slot = r_vnum[SLOT_W-1:0];
                            w_load_data.is_new      = 1'b1;
                            n_vnum = r_vnum + 1'b1;
                        end
                    end
                end else if (w_hit) begin
                    // repeat of a stored triplet
                    if (w_out_free) begin
                        w_load                  = 1'b1;
                        w_load_data.vertex_slot = w_l_vertex;
                        n_state                 = vtd_pkg::BK_IDLE;
                    end
                end else if (w_l_has) begin
                    // follow the chain
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_l_next;
                    n_e       = w_l_next;
                    n_head    = 1'b0;
                end else if (w_pool_full || w_vnum_full) begin
                    if (w_out_free) begin
                        w_load                 = 1'b1;
                        w_load_data.table_full = 1'b1;
                        n_state                = vtd_pkg::BK_IDLE;
                    end
                end else begin
                    // chain end: hook a pool entry and store the key there
                    w_link_we    = 1'b1;
                    w_link_wdata = {1'b1, 1'b1, w_fresh, w_l_vertex};
                    w_key_we     = 1'b1;
                    w_key_waddr  = w_fresh;
                    n_fresh      = w_fresh;
                    n_pool       = r_pool + 1'b1;
                    n_state      = vtd_pkg::BK_LINK;
                end
            end

            // fill the link word of the new pool entry
            vtd_pkg::BK_LINK: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_fresh;
                w_link_wdata = {1'b1, 1'b0, ENTRY_W'(0), r_vnum[SLOT_W-1:0]};
                if (w_out_free) begin
                    w_load                  = 1'b1;
                    w_load_data.vertex_slot = r_vnum[SLOT_W-1:0];
                    w_load_data.is_new      = 1'b1;
                    n_vnum                  = r_vnum + 1'b1;
                    n_state                 = vtd_pkg::BK_IDLE;
                end
            end

            default: begin
                n_state = vtd_pkg::BK_IDLE;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_load_data;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== tb/sv/tb_vertex_triplet_dedup_table.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_triplet_dedup_table
// Self-checking bench for the vertex triplet dedup table. Face corner
// requests go through a directed table and then random meshes. A pass that
// crowds corners into a few buckets runs in the middle to build long chains.
// Every result is checked against a behavioral copy of the chained hash
// table, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vertex_triplet_dedup_table;

    localparam int IDX_W        = 20;
    localparam int BUCKETS      = 4096;
    localparam int POOL_ENTRIES = 4096;
    localparam int TBL_DEPTH    = BUCKETS + POOL_ENTRIES;
    localparam int N_DIR        = 20;
    localparam int RANDOM_ITEMS = 1640;
    localparam int CROWD_ITEMS  = 200;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] pos;
        logic             uvp;
        logic [IDX_W-1:0] uv;
        logic [IDX_W-1:0] nrm;
    } t_corner;

    typedef struct packed {
        t_corner       c;
        logic          known;
        vtd_pkg::t_res want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vtd_req_if #(.IDX_W(IDX_W)) corner_ch ();
    vtd_res_if                  slot_ch ();

    vertex_triplet_dedup_table #(
        .BUCKETS     (BUCKETS),
        .POOL_ENTRIES(POOL_ENTRIES),
        .INDEX_BITS  (IDX_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (corner_ch),
        .o_res  (slot_ch)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // shadow copy of the hash table
    logic [IDX_W-1:0]           key_pos  [TBL_DEPTH];
    logic [IDX_W-1:0]           key_uv   [TBL_DEPTH];
    logic [IDX_W-1:0]           key_nrm  [TBL_DEPTH];
    logic                       key_uvp  [TBL_DEPTH];
    logic                       ent_live [TBL_DEPTH];
    logic                       ent_chain[TBL_DEPTH];
    logic [vtd_pkg::VNUM_W-1:0] ent_vnum [TBL_DEPTH];
    int unsigned                ent_next [TBL_DEPTH];
    int unsigned                vnum_next;
    int unsigned                pool_used;

    vtd_pkg::t_res pending_slots[$];
    t_row          dir_rows[N_DIR];

    int n_sent, n_got, n_mismatch, n_random;
    int n_new, n_hit, n_full, n_clears;

    // empty table, counters back to zero
    function automatic void wipe_table();
        for (int k = 0; k < TBL_DEPTH; k++) begin
            ent_live[k]  = 1'b0;
            ent_chain[k] = 1'b0;
        end
        vnum_next = 0;
        pool_used = 0;
    endfunction

    function automatic void record_triplet(int unsigned e, t_corner c,
                                           logic [IDX_W-1:0] uv_eff);
        key_pos[e]   = c.pos;
        key_uv[e]    = uv_eff;
        key_nrm[e]   = c.nrm;
        key_uvp[e]   = c.uvp;
        ent_live[e]  = 1'b1;
        ent_chain[e] = 1'b0;
        ent_next[e]  = 0;
        ent_vnum[e]  = vtd_pkg::VNUM_W'(vnum_next);
        vnum_next++;
    endfunction

    // look up or insert one corner, returns the result the block must give
    function automatic vtd_pkg::t_res dedup_lookup(t_corner c);
        vtd_pkg::t_res     r;
        logic [IDX_W-1:0]  uv_eff;
        longint unsigned   p, n, u;
        int unsigned       e, fresh;
        r = '0;
        if (c.mode == MODE_CLEAR) begin
            wipe_table();
            n_clears++;
            return r;
        end
        uv_eff = c.uvp ? c.uv : '0;
        p = c.pos;
        n = c.nrm;
        u = uv_eff;
        e = int'((64 * p + 5 * n + 32 * u) % BUCKETS);
        // empty bucket head takes the triplet directly
        if (!ent_live[e]) begin
            if (vnum_next >= vtd_pkg::SLOT_LIMIT) begin
                r.table_full = 1'b1;
                n_full++;
                return r;
            end
            record_triplet(e, c, uv_eff);
            r.vertex_slot = ent_vnum[e][vtd_pkg::SLOT_W-1:0];
            r.is_new      = 1'b1;
            n_new++;
            return r;
        end
        // walk the chain
        while (1) begin
            if (key_pos[e] == c.pos && key_nrm[e] == c.nrm &&
                key_uvp[e] == c.uvp && key_uv[e] == uv_eff) begin
                r.vertex_slot = ent_vnum[e][vtd_pkg::SLOT_W-1:0];
                n_hit++;
                return r;
            end
            if (!ent_chain[e])
                break;
            e = ent_next[e];
        end
        // append from the overflow pool
        if (pool_used >= POOL_ENTRIES || vnum_next >= vtd_pkg::SLOT_LIMIT) begin
            r.table_full = 1'b1;
            n_full++;
            return r;
        end
        fresh = BUCKETS + pool_used;
        pool_used++;
        ent_chain[e] = 1'b1;
        ent_next[e]  = fresh;
        record_triplet(fresh, c, uv_eff);
        r.vertex_slot = ent_vnum[fresh][vtd_pkg::SLOT_W-1:0];
        r.is_new      = 1'b1;
        n_new++;
        return r;
    endfunction

    function automatic t_row dir_row(logic mode, int pos, logic uvp, int uv, int nrm,
                                     logic known, int slot, logic is_new, logic full);
        t_row r;
        r.c.mode            = mode;
        r.c.pos             = IDX_W'(pos);
        r.c.uvp             = uvp;
        r.c.uv              = IDX_W'(uv);
        r.c.nrm             = IDX_W'(nrm);
        r.known             = known;
        r.want.vertex_slot  = vtd_pkg::SLOT_W'(slot);
        r.want.is_new       = is_new;
        r.want.table_full   = full;
        return r;
    endfunction

    // mostly small mesh indices, sometimes extremes or full width
    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return IDX_W'($urandom);
            default: return IDX_W'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic t_corner noise_corner();
        t_corner c;
        c.mode = MODE_LOOKUP;
        c.pos  = IDX_W'($urandom);
        c.uvp  = 1'($urandom_range(0, 1));
        c.uv   = IDX_W'($urandom);
        c.nrm  = IDX_W'($urandom);
        return c;
    endfunction

    // clear request, other fields carry garbage
    function automatic t_corner clear_req();
        t_corner c;
        c      = noise_corner();
        c.mode = MODE_CLEAR;
        return c;
    endfunction

    // drive one request, predict it once accepted
    task automatic offer_corner(input t_corner c, input logic known,
                                input vtd_pkg::t_res want, output vtd_pkg::t_res got);
        int gap;
        gap = (((n_sent / 40) % 5) == 4) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            corner_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        corner_ch.mode           = c.mode;
        corner_ch.position_index = c.pos;
        corner_ch.uv_present     = c.uvp;
        corner_ch.uv_index       = c.uv;
        corner_ch.normal_index   = c.nrm;
        corner_ch.valid          = 1'b1;
        @(posedge i_clk);
        while (!corner_ch.ready) @(posedge i_clk);
        got = dedup_lookup(c);
        if (known)
            pending_slots = {pending_slots, want};
        else
            pending_slots = {pending_slots, got};
        n_sent++;
        @(negedge i_clk);
    endtask

    // one mesh: a set of distinct triplets, then corners mostly drawn from it
    task automatic run_mesh();
        t_corner       base[$];
        t_corner       c;
        vtd_pkg::t_res got;
        int            n_base, n_corners, r;
        if ($urandom_range(0, 3) != 0) begin
            offer_corner(clear_req(), 1'b0, '0, got);
            n_random++;
        end
        n_base = $urandom_range(3, 48);
        for (int k = 0; k < n_base; k++) begin
            if (base.size() > 0 && $urandom_range(0, 2) == 0) begin
                // same bucket as an earlier triplet, forces chaining
                c     = base[$urandom_range(0, base.size() - 1)];
                c.pos = c.pos + IDX_W'(64 * $urandom_range(1, 8));
            end else begin
                c.mode = MODE_LOOKUP;
                c.pos  = pick_index();
                c.nrm  = pick_index();
                c.uvp  = ($urandom_range(0, 3) != 0);
                c.uv   = pick_index();
            end
            base = {base, c};
        end
        n_corners = $urandom_range(20, 140);
        for (int k = 0; k < n_corners; k++) begin
            r = $urandom_range(0, 299);
            c = base[$urandom_range(0, base.size() - 1)];
            if (r < 24)
                c = noise_corner();
            else if (r < 48)
                c.uvp = ~c.uvp;
            else if (r == 299)
                c = clear_req();
            offer_corner(c, 1'b0, '0, got);
            n_random++;
        end
    endtask

    // pile corners into 64 buckets so the chains grow long
    task automatic crowd_buckets();
        t_corner       kept[$];
        t_corner       c;
        vtd_pkg::t_res got;
        offer_corner(clear_req(), 1'b0, '0, got);
        for (int k = 0; k < CROWD_ITEMS; k++) begin
            c.mode = MODE_LOOKUP;
            c.pos  = IDX_W'($urandom);
            c.nrm  = IDX_W'($urandom) & ~IDX_W'(63);
            c.uvp  = 1'($urandom_range(0, 1));
            c.uv   = IDX_W'($urandom) & ~IDX_W'(1);
            offer_corner(c, 1'b0, '0, got);
            if (kept.size() < 16)
                kept = {kept, c};
        end
        // stored triplets still resolve after their chains have grown
        foreach (kept[k])
            offer_corner(kept[k], 1'b0, '0, got);
        offer_corner(clear_req(), 1'b0, '0, got);
    endtask

    // request side and end of run
    initial begin : request_source
        vtd_pkg::t_res got;
        corner_ch.valid          = 1'b0;
        corner_ch.mode           = MODE_LOOKUP;
        corner_ch.position_index = '0;
        corner_ch.uv_present     = 1'b0;
        corner_ch.uv_index       = '0;
        corner_ch.normal_index   = '0;
        i_rst_n = 1'b0;
        n_sent = 0; n_random = 0;
        n_new = 0; n_hit = 0; n_full = 0; n_clears = 0;
        wipe_table();

        // directed table: known results typed in, the rest predicted
        dir_rows[0]  = dir_row(MODE_CLEAR,  0,       0, 0,       0,       1, 0, 0, 0);
        dir_rows[1]  = dir_row(MODE_LOOKUP, 0,       0, 0,       0,       1, 0, 1, 0);
        dir_rows[2]  = dir_row(MODE_LOOKUP, 0,       0, 0,       0,       1, 0, 0, 0);
        dir_rows[3]  = dir_row(MODE_LOOKUP, 'hFFFFF, 1, 'hFFFFF, 'hFFFFF, 1, 1, 1, 0);
        dir_rows[4]  = dir_row(MODE_LOOKUP, 'hFFFFF, 1, 'hFFFFF, 'hFFFFF, 1, 1, 0, 0);
        // missing uv is a different triplet
        dir_rows[5]  = dir_row(MODE_LOOKUP, 'hFFFFF, 0, 'hFFFFF, 'hFFFFF, 0, 0, 0, 0);
        // same bucket as the first corner, uv present
        dir_rows[6]  = dir_row(MODE_LOOKUP, 0,       1, 0,       0,       0, 0, 0, 0);
        // uv index ignored when uv absent
        dir_rows[7]  = dir_row(MODE_LOOKUP, 0,       0, 'h5A5A5, 0,       1, 0, 0, 0);
        dir_rows[8]  = dir_row(MODE_LOOKUP, 64,      0, 0,       0,       0, 0, 0, 0);
        dir_rows[9]  = dir_row(MODE_LOOKUP, 0,       1, 0,       0,       0, 0, 0, 0);
        dir_rows[10] = dir_row(MODE_LOOKUP, 64,      0, 0,       0,       0, 0, 0, 0);
        dir_rows[11] = dir_row(MODE_LOOKUP, 1,       0, 0,       0,       0, 0, 0, 0);
        dir_rows[12] = dir_row(MODE_LOOKUP, 0,       1, 2,       0,       0, 0, 0, 0);
        dir_rows[13] = dir_row(MODE_LOOKUP, 'h80000, 1, 1,       'h40000, 0, 0, 0, 0);
        dir_rows[14] = dir_row(MODE_LOOKUP, 0,       0, 0,       'hFFFFF, 0, 0, 0, 0);
        dir_rows[15] = dir_row(MODE_CLEAR,  'hFFFFF, 1, 'hFFFFF, 'hFFFFF, 1, 0, 0, 0);
        dir_rows[16] = dir_row(MODE_LOOKUP, 0,       0, 0,       0,       1, 0, 1, 0);
        dir_rows[17] = dir_row(MODE_LOOKUP, 'h12345, 1, 'h6789A, 'h0BCDE, 0, 0, 0, 0);
        dir_rows[18] = dir_row(MODE_LOOKUP, 'h12345, 1, 'h6789A, 'h0BCDE, 0, 0, 0, 0);
        dir_rows[19] = dir_row(MODE_CLEAR,  0,       0, 0,       0,       1, 0, 0, 0);

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < N_DIR; k++)
            offer_corner(dir_rows[k].c, dir_rows[k].known, dir_rows[k].want, got);

        // random meshes around one crowded-bucket pass
        while (n_random < RANDOM_ITEMS / 2)
            run_mesh();
        crowd_buckets();
        while (n_random < RANDOM_ITEMS)
            run_mesh();
        corner_ch.valid = 1'b0;

        while (pending_slots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d results, %0d clears", n_sent, n_got, n_clears);
        $display("%0d new vertices, %0d repeats, %0d refused on a full table",
                 n_new, n_hit, n_full);
        if (n_mismatch == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, one long hold-off, field checks
    initial begin : result_sink
        int            stall;
        logic          hold_done;
        vtd_pkg::t_res want;
        slot_ch.ready = 1'b0;
        n_got      = 0;
        n_mismatch = 0;
        hold_done  = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (n_got == HOLD_AFTER && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                stall = (((n_got / 40) % 5) == 2) ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                slot_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            slot_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!slot_ch.valid) @(posedge i_clk);
            if (pending_slots.size() == 0) begin
                $error("result with no request pending: vertex_slot %0d is_new %0b",
                       slot_ch.vertex_slot, slot_ch.is_new);
                n_mismatch++;
            end else begin
                want = pending_slots.pop_front();
                if (slot_ch.vertex_slot !== want.vertex_slot) begin
                    $error("vertex_slot: expected %0d, got %0d",
                           want.vertex_slot, slot_ch.vertex_slot);
                    n_mismatch++;
                end
                if (slot_ch.is_new !== want.is_new) begin
                    $error("is_new: expected %0b, got %0b", want.is_new, slot_ch.is_new);
                    n_mismatch++;
                end
                if (slot_ch.table_full !== want.table_full) begin
                    $error("table_full: expected %0b, got %0b",
                           want.table_full, slot_ch.table_full);
                    n_mismatch++;
                end
            end
            n_got++;
            @(negedge i_clk);
        end
    end

    // watchdog
    initial begin : watchdog
        #60_000_000;
        $display("timeout with %0d results pending", pending_slots.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
design/vtd_pkg.sv
design/vtd_ifs.sv
design/vtd_front.sv
design/vtd_fifo.sv
design/vtd_back.sv
design/vertex_triplet_dedup_table.sv
tb/sv/tb_vertex_triplet_dedup_table.sv
